FILE: hw/rtl/itda_pkg.sv
// ----------------------------------------------------------------------------
// itda_pkg: shared types and constants of the decimal ASCII printer
// Holds the queue entry layout, the converter state type, the character
// codes and the BCD adjust step used by the double-dabble converter.
// ----------------------------------------------------------------------------
package itda_pkg;

   localparam int unsigned VALUE_W       = 64;
   localparam int unsigned DIGITS        = 20;
   localparam int unsigned BCD_W         = DIGITS * 4;
   localparam int unsigned BITS_PER_STEP = 4;
   localparam int unsigned CONV_STEPS    = VALUE_W / BITS_PER_STEP;
   localparam int unsigned QUEUE_DEPTH   = 2;
   localparam int unsigned CNT_W         = $clog2(DIGITS + 1);

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // One classified beat waiting for the converter
   typedef struct packed {
      logic               neg;
      logic [VALUE_W-1:0] mag;
   } itda_entry_type;

   // Queue status seen by the front end
   typedef struct packed {
      logic full;
      logic valid;
   } itda_qstat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_EMIT
   } itda_state_type;

   // Add three to every BCD digit of five or more, ahead of a left shift
   function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
      logic [BCD_W-1:0] res;
      res = bcd;
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd[d*4 +: 4] >= 4'd5) begin
            res[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
         end
      end
      return res;
   endfunction

endpackage

FILE: hw/rtl/itda_front.sv
// ----------------------------------------------------------------------------
// itda_front: request front end
// Accepts a request beat when the queue has room, reads the word as signed
// or unsigned and forms the sign flag and the magnitude for the queue.
// ----------------------------------------------------------------------------
module itda_front (
   input  logic                   start,
   input  logic [63:0]            req_value_bits,
   input  logic                   req_signed_mode,
   input  itda_pkg::itda_qstat_type q_stat,
   output logic                   busy,
   output logic                   push,
   output itda_pkg::itda_entry_type push_entry
);
   import itda_pkg::*;

   logic neg;

   // Hold off new beats while the queue is full
   assign busy = q_stat.full;
   assign push = start & ~q_stat.full;

   // Classify: negative only in signed mode with the top bit set
   assign neg = req_signed_mode & req_value_bits[VALUE_W-1];

   always_comb begin
      push_entry.neg = neg;
      push_entry.mag = neg ? (VALUE_W'(0) - req_value_bits) : req_value_bits;
   end

endmodule

FILE: hw/rtl/itda_queue.sv
// ----------------------------------------------------------------------------
// itda_queue: short queue between front end and converter
// Two-entry FIFO of classified beats, so each side can stall on its own.
// ----------------------------------------------------------------------------
module itda_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  itda_pkg::itda_entry_type push_entry,
   input  logic                     pop,
   output itda_pkg::itda_qstat_type q_stat,
   output itda_pkg::itda_entry_type head
);
   import itda_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

   itda_entry_type   store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Write the entry payload
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign q_stat.full  = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign q_stat.valid = (fill_ff != '0);
   assign head         = store_ff[rd_ptr_ff];

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && q_stat.full && !pop)) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_stat.valid) else $error("pop from empty queue");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(QUEUE_DEPTH)) else $error("queue fill overflow");

endmodule

FILE: hw/rtl/itda_back.sv
// ----------------------------------------------------------------------------
// itda_back: binary to decimal converter and character emitter
// Converts the magnitude by double dabble, four bits a cycle, then scans
// the twenty BCD digits from the top, dropping leading zeros.
// ----------------------------------------------------------------------------
module itda_back (
   input  logic                     clock,
   input  logic                     reset,
   input  itda_pkg::itda_qstat_type q_stat,
   input  itda_pkg::itda_entry_type head,
   output logic                     pop,
   output logic                     rsp_strobe,
   output logic [7:0]               rsp_text_char,
   output logic                     rsp_last_char
);
   import itda_pkg::*;

   itda_state_type     state_ff, state_in;
   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic               seen_ff, seen_in;
   logic               strobe_ff, strobe_in;
   logic [7:0]         char_ff, char_in;
   logic               last_ff, last_in;

   logic [BCD_W-1:0]   bcd_v;
   logic [VALUE_W-1:0] bin_v;
   logic [3:0]         top_digit;
   logic               is_last;
   logic               show;

   assign top_digit = bcd_ff[BCD_W-1 -: 4];
   assign is_last   = (cnt_ff == CNT_W'(DIGITS - 1));
   assign show      = (top_digit != 4'd0) | seen_ff | is_last;

   // Four double-dabble steps on the current word
   always_comb begin
      bcd_v = bcd_ff;
      bin_v = bin_ff;
      for (int s = 0; s < BITS_PER_STEP; s++) begin
         bcd_v = bcd_adjust(bcd_v);
         {bcd_v, bin_v} = {bcd_v[BCD_W-2:0], bin_v, 1'b0};
      end
   end

   // Next state and outputs
   always_comb begin
      state_in  = state_ff;
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      seen_in   = seen_ff;
      strobe_in = 1'b0;
      char_in   = char_ff;
      last_in   = 1'b0;
      pop       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_stat.valid) begin
               pop      = 1'b1;
               bin_in   = head.mag;
               neg_in   = head.neg;
               bcd_in   = '0;
               cnt_in   = '0;
               seen_in  = 1'b0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bin_in = bin_v;
            bcd_in = bcd_v;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CONV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            strobe_in = 1'b1;
            char_in   = CHAR_MINUS;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            strobe_in = show;
            char_in   = CHAR_ZERO + {4'd0, top_digit};
            last_in   = is_last;
            seen_in   = show;
            bcd_in    = {bcd_ff[BCD_W-5:0], 4'd0};
            cnt_in    = cnt_ff + 1'b1;
            if (is_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         seen_ff   <= 1'b0;
         neg_ff    <= 1'b0;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         seen_ff   <= seen_in;
         neg_ff    <= neg_in;
         strobe_ff <= strobe_in;
         last_ff   <= last_in;
      end
   end

   // Datapath registers need no reset
   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      char_ff <= char_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_text_char = char_ff;
   assign rsp_last_char = last_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == ST_IDLE)) else $error("pop outside idle");
   a_last_has_strobe: assert property (@(posedge clock) disable iff (reset)
      last_ff |-> strobe_ff) else $error("last flag without strobe");
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && last_ff) |=> !strobe_ff) else $error("beat right after last");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (cnt_ff <= CNT_W'(DIGITS - 1)))
      else $error("digit counter overrun");

endmodule

FILE: hw/rtl/integer_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii: 64-bit word to decimal ASCII text
// Prints one word, unsigned or two's complement, as a run of characters.
//
// Request channel: drive req_value_bits and req_signed_mode with start high;
// the beat is taken at a rising edge where start is high and busy is low.
// busy rises when the two-entry request queue is full.
// Response channel: each character appears for one cycle with rsp_strobe
// high, most significant first; rsp_last_char marks the final one. A
// negative signed value opens with '-'. The receiver cannot stall.
// Converter: it pops an item from the queue while idle, runs double dabble
// four bits a cycle over 64 bits, emits '-' for a negative value, then
// scans all 20 digit places, one a cycle, and only then returns to idle
// for the next item. Leading zeros are skipped silently, so strobes may
// come with gaps.
// Reset empties the queue and returns the converter to idle.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_value_bits,
   input  logic        req_signed_mode,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_text_char,
   output logic        rsp_last_char
);
   import itda_pkg::*;

   itda_qstat_type q_stat;
   itda_entry_type push_entry;
   itda_entry_type head;
   logic           push;
   logic           pop;

   itda_front u_front (
      .start           (start),
      .req_value_bits  (req_value_bits),
      .req_signed_mode (req_signed_mode),
      .q_stat          (q_stat),
      .busy            (busy),
      .push            (push),
      .push_entry      (push_entry)
   );

   itda_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .q_stat     (q_stat),
      .head       (head)
   );

   itda_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_stat        (q_stat),
      .head          (head),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

FILE: sim/integer_to_decimal_ascii_tb.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_tb: self-checking bench for the decimal printer
// Feeds 64-bit words, unsigned and two's complement, through the command
// port with random gaps. Each accepted word is expanded locally, or taken
// from the directed table, into the decimal characters it should print.
// Every strobed character is compared with the oldest expected one. A short
// directed table comes first, then random words of mixed magnitude.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_to_decimal_ascii_tb;

   import itda_pkg::*;

   // One expected output character
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } text_beat_type;

   // One directed row: an all-zero text means the predictor supplies the answer
   typedef struct packed {
      logic [63:0]  value;
      logic         mode;
      logic [159:0] text;
   } stim_row_type;

   localparam int unsigned NUM_ROWS    = 21;
   localparam int unsigned NUM_RANDOM  = 110;
   localparam int unsigned DRAIN_WAIT  = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_value_bits = '0;
   logic        req_signed_mode = 1'b0;
   logic        rsp_strobe;
   logic [7:0]  rsp_text_char;
   logic        rsp_last_char;

   text_beat_type pending_chars[$];
   int unsigned   mismatches = 0;
   stim_row_type  stim_rows [NUM_ROWS];

   integer_to_decimal_ascii dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value_bits  (req_value_bits),
      .req_signed_mode (req_signed_mode),
      .rsp_strobe      (rsp_strobe),
      .rsp_text_char   (rsp_text_char),
      .rsp_last_char   (rsp_last_char)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs
   initial begin
      #1000000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   // Expand one word into its decimal characters, most significant first
   function automatic void format_decimal(input logic [63:0] bits, input logic mode);
      logic          neg;
      logic [63:0]   mag;
      logic [3:0]    digits [20];
      int            n;
      text_beat_type beat;
      neg = mode & bits[63];
      mag = neg ? (64'd0 - bits) : bits;
      n   = 0;
      do begin
         digits[n] = 4'(mag % 64'd10);
         n++;
         mag = mag / 64'd10;
      end while (mag != 64'd0);
      if (neg) begin
         beat.ch   = CHAR_MINUS;
         beat.last = 1'b0;
         pending_chars.push_back(beat);
      end
      for (int i = n - 1; i >= 0; i--) begin
         beat.ch   = CHAR_ZERO + 8'(digits[i]);
         beat.last = (i == 0);
         pending_chars.push_back(beat);
      end
   endfunction

   // Draw a word: full random, random bit length, small negative, or extreme
   function automatic logic [63:0] random_word();
      logic [63:0] w;
      int unsigned len;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0, 1: ;
         2, 3: begin
            len = $urandom_range(1, 64);
            w   = w & ((64'd1 << len) - 64'd1);
         end
         4: w = 64'd0 - 64'($urandom_range(0, 100000));
         default: begin
            case ($urandom_range(0, 3))
               0: w = 64'd0;
               1: w = '1;
               2: w = 64'h8000_0000_0000_0000;
               default: w = 64'h7FFF_FFFF_FFFF_FFFF;
            endcase
         end
      endcase
      return w;
   endfunction

   // Present one beat after a gap, hold it until taken, then queue its text
   task automatic send_number(input logic [63:0] v, input logic mode,
                              input logic [159:0] text, input int unsigned gap);
      text_beat_type beat;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start           <= 1'b1;
      req_value_bits  <= v;
      req_signed_mode <= mode;
      do @(posedge clock); while (busy !== 1'b0);
      if (text == '0) begin
         format_decimal(v, mode);
      end else begin
         for (int b = 19; b >= 0; b--) begin
            if (text[b*8 +: 8] != 8'h00) begin
               beat.ch   = text[b*8 +: 8];
               beat.last = (b == 0);
               pending_chars.push_back(beat);
            end
         end
      end
      @(negedge clock);
   endtask

   // Compare every strobed character with the oldest expectation
   always @(posedge clock) begin : check_output
      text_beat_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character 8'h%02h last=%0b",
                                      rsp_text_char, rsp_last_char));
         end else begin
            want = pending_chars.pop_front();
            if (rsp_text_char !== want.ch) begin
               report_mismatch($sformatf("text_char 8'h%02h, expected 8'h%02h",
                                         rsp_text_char, want.ch));
            end
            if (rsp_last_char !== want.last) begin
               report_mismatch($sformatf("last_char %0b, expected %0b (char 8'h%02h)",
                                         rsp_last_char, want.last, want.ch));
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned gap;
      // Extremes, zero in both modes and the sign boundary
      stim_rows[0]  = '{64'd0, 1'b0, "0"};
      stim_rows[1]  = '{64'd0, 1'b1, "0"};
      stim_rows[2]  = '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, "18446744073709551615"};
      stim_rows[3]  = '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, "-1"};
      stim_rows[4]  = '{64'h8000_0000_0000_0000, 1'b1, "-9223372036854775808"};
      stim_rows[5]  = '{64'h8000_0000_0000_0000, 1'b0, "9223372036854775808"};
      stim_rows[6]  = '{64'h7FFF_FFFF_FFFF_FFFF, 1'b1, "9223372036854775807"};
      stim_rows[7]  = '{64'd1, 1'b0, "1"};
      stim_rows[8]  = '{64'd9, 1'b0, "9"};
      stim_rows[9]  = '{64'd10, 1'b1, "10"};
      stim_rows[10] = '{64'd10000000000000000000, 1'b0, "10000000000000000000"};
      stim_rows[11] = '{64'd9999999999999999999, 1'b0, "9999999999999999999"};
      stim_rows[12] = '{64'hFFFF_FFFF_FFFF_FFF6, 1'b1, "-10"};
      // Left to the predictor
      stim_rows[13] = '{64'h8000_0000_0000_0001, 1'b1, 160'd0};
      stim_rows[14] = '{64'h0123_4567_89AB_CDEF, 1'b0, 160'd0};
      stim_rows[15] = '{64'hFEDC_BA98_7654_3210, 1'b1, 160'd0};
      stim_rows[16] = '{64'hFEDC_BA98_7654_3210, 1'b0, 160'd0};
      stim_rows[17] = '{64'd12345678901234567890, 1'b0, 160'd0};
      stim_rows[18] = '{64'd1000, 1'b1, 160'd0};
      stim_rows[19] = '{64'h5555_5555_5555_5555, 1'b1, 160'd0};
      stim_rows[20] = '{64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 160'd0};

      // Hold reset, then release it on a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table
      for (int r = 0; r < NUM_ROWS; r++) begin
         send_number(stim_rows[r].value, stim_rows[r].mode, stim_rows[r].text,
                     $urandom_range(0, 8));
      end

      // Random words; back-to-back stretch in the middle, one full drain
      for (int i = 0; i < NUM_RANDOM; i++) begin
         gap = (i >= 40 && i < 60) ? 0 : $urandom_range(0, 8);
         if (i == 80) begin
            start <= 1'b0;
            while (pending_chars.size() != 0) @(negedge clock);
            gap = 0;
         end
         send_number(random_word(), 1'($urandom_range(0, 1)), 160'd0, gap);
      end
      start <= 1'b0;

      // Drain, then allow for any stray characters
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
